FILE: hw/rtl/nlpsc_pkg.sv
// Shared types and constants for the length-prefix to start-code converter.
// No dependencies; imported by every module of the block.
package nlpsc_pkg;

    // Parser phase of the front end
    typedef enum logic [1:0] {
        PH_LEN,
        PH_FIRST,
        PH_BODY,
        PH_ERR
    } t_phase;

    // Unit status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_ZERO_LEN = 3'd2,
        ST_OVERRUN  = 3'd3,
        ST_FORBID   = 3'd4
    } t_status;

    // What the back end has to emit for one queued job
    typedef enum logic [1:0] {
        KIND_STATUS,    // single status-only beat
        KIND_BYTE,      // one NAL byte
        KIND_START      // start code then the NAL byte
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       done;
        t_status    status;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    localparam logic [2:0] LEN_FIELD_MIN   = 3'd1;
    localparam logic [2:0] LEN_FIELD_MAX   = 3'd4;
    localparam logic [2:0] LEN_FIELD_RESET = 3'd4;
    localparam logic [2:0] LEN_CNT_MAX     = 3'd7;
    localparam int         FORBIDDEN_BIT   = 7;
    // beat index of the 01 byte, and of the NAL byte after the start code
    localparam logic [2:0] SC_ONE_BEAT     = 3'd3;
    localparam logic [2:0] SC_LAST_BEAT    = 3'd4;
    localparam logic [7:0] SC_ZERO         = 8'h00;
    localparam logic [7:0] SC_ONE          = 8'h01;

    // Clamp the configured prefix length to 1..4
    function automatic logic [2:0] eff_len(input logic [2:0] cfg);
        logic [2:0] l;
        l = cfg;
        if (l < LEN_FIELD_MIN) l = LEN_FIELD_MIN;
        if (l > LEN_FIELD_MAX) l = LEN_FIELD_MAX;
        return l;
    endfunction

endpackage

FILE: hw/rtl/nlpsc_front.sv
// Front end: takes input beats, parses length prefixes, classifies each byte
// into a job for the back end. Depends on nlpsc_pkg.
module nlpsc_front
    import nlpsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_unit_last,
    input  t_qstat     i_qstat,
    output logic       o_push,
    output t_job       o_job
);

    logic [2:0]  r_len_bytes;
    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_left, n_left;
    t_status     r_err, n_err;

    logic        accept;
    logic        clear;
    logic [31:0] acc_sh;
    logic [2:0]  cnt_inc;
    logic [31:0] left_dec;

    assign o_in_ready = !i_qstat.full;
    assign accept     = i_in_valid && o_in_ready;
    assign acc_sh     = {r_acc[23:0], i_data_byte};
    assign cnt_inc    = (r_cnt < LEN_CNT_MAX) ? r_cnt + 3'd1 : r_cnt;
    assign left_dec   = r_left - 32'd1;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_bytes <= LEN_FIELD_RESET;
        end else if (i_cfg_we) begin
            r_len_bytes <= i_cfg_wdata;
        end
    end

    // Parser next state and job generation
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_left  = r_left;
        n_err   = r_err;
        clear   = 1'b0;
        o_push  = 1'b0;
        o_job   = '{kind: KIND_STATUS, data: SC_ZERO, done: 1'b1, status: ST_OK};
        if (accept) begin
            unique case (r_phase) inside
                PH_LEN: begin
                    n_acc = acc_sh;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= eff_len(r_len_bytes)) begin
                        if (acc_sh == 32'd0) begin
                            n_err   = ST_ZERO_LEN;
                            n_phase = PH_ERR;
                            if (i_unit_last) begin
                                o_push       = 1'b1;
                                o_job.status = ST_ZERO_LEN;
                                clear        = 1'b1;
                            end
                        end else begin
                            n_left  = acc_sh;
                            n_phase = PH_FIRST;
                            if (i_unit_last) begin
                                o_push       = 1'b1;
                                o_job.status = ST_OVERRUN;
                                clear        = 1'b1;
                            end
                        end
                    end else if (i_unit_last) begin
                        o_push       = 1'b1;
                        o_job.status = ST_TRUNC;
                        clear        = 1'b1;
                    end
                end
                PH_FIRST, PH_BODY: begin
                    if (r_phase == PH_FIRST && i_data_byte[FORBIDDEN_BIT]) begin
                        // forbidden bit: drop the byte and its start code
                        if (i_unit_last) begin
                            o_push       = 1'b1;
                            o_job.status = (r_left > 32'd1) ? ST_OVERRUN : ST_FORBID;
                            clear        = 1'b1;
                        end else begin
                            n_err   = ST_FORBID;
                            n_phase = PH_ERR;
                        end
                    end else begin
                        o_push     = 1'b1;
                        o_job.kind = (r_phase == PH_FIRST) ? KIND_START : KIND_BYTE;
                        o_job.data = i_data_byte;
                        n_left     = left_dec;
                        if (i_unit_last) begin
                            o_job.status = (left_dec != 32'd0) ? ST_OVERRUN : ST_OK;
                            clear        = 1'b1;
                        end else begin
                            o_job.done = 1'b0;
                            if (left_dec == 32'd0) begin
                                n_phase = PH_LEN;
                                n_cnt   = '0;
                                n_acc   = '0;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end
                    end
                end
                PH_ERR: begin
                    if (i_unit_last) begin
                        o_push       = 1'b1;
                        o_job.status = r_err;
                        clear        = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_LEN;
                end
            endcase
        end
        // unit closed: back to the reset view
        if (clear) begin
            n_phase = PH_LEN;
            n_cnt   = '0;
            n_acc   = '0;
            n_left  = '0;
            n_err   = ST_OK;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_left  <= '0;
            r_err   <= ST_OK;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_err   <= n_err;
        end
    end

endmodule

FILE: hw/rtl/nlpsc_queue.sv
// Short job queue between front and back end.
// Depends on nlpsc_pkg for the job type.
module nlpsc_queue
    import nlpsc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_qstat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/nlpsc_back.sv
// Back end: expands queued jobs into output beats (start code, NAL byte,
// status). Depends on nlpsc_pkg.
module nlpsc_back
    import nlpsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  t_qstat     i_qstat,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_end,
    output logic       o_unit_done,
    output logic [2:0] o_status
);

    t_job       r_job;
    logic       r_busy;
    logic [2:0] r_beat;
    logic       take, final_beat;

    assign take       = r_busy && i_out_ready;
    assign final_beat = (r_job.kind == KIND_START) ? (r_beat == SC_LAST_BEAT) : 1'b1;
    assign o_pop      = !i_qstat.empty && (!r_busy || (take && final_beat));

    // Beat payload
    always_comb begin
        o_out_valid  = r_busy;
        o_run_end    = final_beat;
        o_unit_done  = final_beat && r_job.done;
        o_status     = (final_beat && r_job.done) ? r_job.status : ST_OK;
        o_byte_valid = 1'b1;
        o_out_byte   = r_job.data;
        unique case (r_job.kind)
            KIND_STATUS: begin
                o_byte_valid = 1'b0;
                o_out_byte   = SC_ZERO;
            end
            KIND_BYTE: begin
                o_out_byte = r_job.data;
            end
            KIND_START: begin
                if (r_beat == SC_ONE_BEAT) begin
                    o_out_byte = SC_ONE;
                end else if (r_beat < SC_ONE_BEAT) begin
                    o_out_byte = SC_ZERO;
                end
            end
            default: begin
                o_out_byte = r_job.data;
            end
        endcase
    end

    // Current job
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    // Beat sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_beat <= '0;
        end else if (take) begin
            if (final_beat) begin
                r_busy <= 1'b0;
            end
            r_beat <= r_beat + 3'd1;
        end
    end

endmodule

FILE: hw/rtl/nal_length_prefix_to_start_code_top.sv
// Top level of the length-prefixed to start-code byte stream converter.
// Depends on nlpsc_pkg, nlpsc_front, nlpsc_queue, nlpsc_back.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_data_byte, i_unit_last
//  out     | output    | o_out_valid / i_out_ready  | o_out_byte, o_byte_valid,
//          |           |                            | o_run_end, o_unit_done, o_status
//  cfg     | input     | i_cfg_we                   | i_cfg_wdata
//
// One input beat per cycle while the job queue has room. The back end emits
// one beat per cycle while i_out_ready is high: one for a plain NAL byte or a status, five for the first
// byte of a NAL (00 00 00 01 and the byte). Length prefix bytes and bytes after
// an error give no output beat. Synchronous active-low reset; no clearing pass.
// Output stalls fill the queue and then drop o_in_ready.
module nal_length_prefix_to_start_code_top
    import nlpsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_unit_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_end,
    output logic       o_unit_done,
    output logic [2:0] o_status
);

    t_qstat qstat;
    t_job   push_job, head_job;
    logic   push, pop;

    nlpsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_unit_last (i_unit_last),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_job       (push_job)
    );

    nlpsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (qstat)
    );

    nlpsc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_job),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_end    (o_run_end),
        .o_unit_done  (o_unit_done),
        .o_status     (o_status)
    );

endmodule

FILE: hw/rtl/nlpsc_checker.sv
// Port-level checks for the converter top level, bound in below.
// Depends on nlpsc_pkg and nal_length_prefix_to_start_code_top.
module nlpsc_checker
    import nlpsc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_run_end,
    input logic       o_unit_done,
    input logic [2:0] o_status
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_byte_valid) && $stable(o_run_end)
            && $stable(o_unit_done) && $stable(o_status))
        else $error("output beat changed while stalled");

    // a closing beat is always the last of its run
    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_unit_done |-> o_run_end)
        else $error("unit_done without run_end");

    // status only shows on the closing beat
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_unit_done)
        else $error("status set on a non-closing beat");

    // status-only beat closes the unit and carries a zero byte
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_run_end && o_unit_done
            && (o_out_byte == SC_ZERO))
        else $error("malformed status-only beat");

    // mid-run beats are start code bytes
    a_start_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid && !o_run_end |->
            ((o_out_byte == SC_ZERO) || (o_out_byte == SC_ONE)) && !o_unit_done)
        else $error("unexpected byte inside a start code run");

endmodule

bind nal_length_prefix_to_start_code_top nlpsc_checker u_nlpsc_checker (.*);

FILE: test/tb_nal_length_prefix_to_start_code_top.sv
// Self-checking testbench for nal_length_prefix_to_start_code_top: builds access units,
// predicts the start-code output stream beat by beat and compares it with the block.
// Depends on nlpsc_pkg and the top level of the converter.
`timescale 1ns / 100ps

module tb_nal_length_prefix_to_start_code_top;
    import nlpsc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASE_BYTES = 12;

    // One expected output beat
    typedef struct packed {
        logic [7:0] data;
        logic       carries;
        logic       run_end;
        logic       closes;
        t_status    status;
    } t_out_beat;

    // Tracks the parser state of the converter and the beats it still owes
    class t_annexb_tracker;
        logic [2:0]  width_reg;
        t_phase      phase;
        logic [2:0]  field_count;
        logic [31:0] field_acc;
        logic [31:0] nal_left;
        t_status     sticky;
        t_out_beat   due[$];
        int unsigned fails;

        function new();
            width_reg = LEN_FIELD_RESET;
            fails = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_LEN;
            field_count = '0;
            field_acc = '0;
            nal_left = '0;
            sticky = ST_OK;
        endfunction

        // Out-of-range settings clamp to 1..4
        function int unsigned prefix_len();
            if (width_reg < LEN_FIELD_MIN) return LEN_FIELD_MIN;
            if (width_reg > LEN_FIELD_MAX) return LEN_FIELD_MAX;
            return width_reg;
        endfunction

        function void emit(logic [7:0] d, logic c, logic re, logic ud, t_status st);
            t_out_beat bt;
            bt.data = d;
            bt.carries = c;
            bt.run_end = re;
            bt.closes = ud;
            bt.status = st;
            due.push_back(bt);
        endfunction

        function void close_unit(t_status st);
            emit(8'h00, 1'b0, 1'b1, 1'b1, st);
            restart();
        endfunction

        // A NAL byte passes through; the unit's last byte carries the status
        function void pass_byte(logic [7:0] b, logic last);
            nal_left = nal_left - 32'd1;
            if (last) begin
                if (nal_left != 0) emit(b, 1'b1, 1'b1, 1'b1, ST_OVERRUN);
                else emit(b, 1'b1, 1'b1, 1'b1, ST_OK);
                restart();
            end else begin
                emit(b, 1'b1, 1'b1, 1'b0, ST_OK);
                if (nal_left == 0) begin
                    phase = PH_LEN;
                    field_count = '0;
                    field_acc = '0;
                end else begin
                    phase = PH_BODY;
                end
            end
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            case (phase)
                PH_LEN: begin
                    field_acc = {field_acc[23:0], b};
                    if (field_count < LEN_CNT_MAX) field_count = field_count + 3'd1;
                    if (field_count >= prefix_len()) begin
                        if (field_acc == 0) begin
                            if (last) close_unit(ST_ZERO_LEN);
                            else begin
                                sticky = ST_ZERO_LEN;
                                phase = PH_ERR;
                            end
                        end else begin
                            nal_left = field_acc;
                            phase = PH_FIRST;
                            if (last) close_unit(ST_OVERRUN);
                        end
                    end else if (last) begin
                        close_unit(ST_TRUNC);
                    end
                end
                PH_FIRST: begin
                    if (b[FORBIDDEN_BIT]) begin
                        // forbidden bit: nothing given; an overrun wins on the last byte
                        if (last) begin
                            if (nal_left > 1) close_unit(ST_OVERRUN);
                            else close_unit(ST_FORBID);
                        end else begin
                            sticky = ST_FORBID;
                            phase = PH_ERR;
                        end
                    end else begin
                        emit(SC_ZERO, 1'b1, 1'b0, 1'b0, ST_OK);
                        emit(SC_ZERO, 1'b1, 1'b0, 1'b0, ST_OK);
                        emit(SC_ZERO, 1'b1, 1'b0, 1'b0, ST_OK);
                        emit(SC_ONE, 1'b1, 1'b0, 1'b0, ST_OK);
                        pass_byte(b, last);
                    end
                end
                PH_BODY: pass_byte(b, last);
                default: begin
                    // error is sticky until the unit closes
                    if (last) close_unit(sticky);
                end
            endcase
        endfunction

        function void check_beat(logic [7:0] ob, logic bv, logic re, logic ud, logic [2:0] st);
            t_out_beat want;
            if (due.size() == 0) begin
                $error("unexpected output beat: out_byte %0h byte_valid %0b", ob, bv);
                fails++;
                return;
            end
            want = due.pop_front();
            if (ob !== want.data) begin
                $error("out_byte: expected %0h, got %0h", want.data, ob);
                fails++;
            end
            if (bv !== want.carries) begin
                $error("byte_valid: expected %0b, got %0b", want.carries, bv);
                fails++;
            end
            if (re !== want.run_end) begin
                $error("run_end: expected %0b, got %0b", want.run_end, re);
                fails++;
            end
            if (ud !== want.closes) begin
                $error("unit_done: expected %0b, got %0b", want.closes, ud);
                fails++;
            end
            if (st !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, st);
                fails++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_data_byte;
    logic       i_unit_last;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_run_end;
    logic       o_unit_done;
    logic [2:0] o_status;

    t_annexb_tracker sb;
    logic [7:0]      au_bytes[$];
    logic            steady;
    int              sent_bytes;
    int              cycles = 0;

    nal_length_prefix_to_start_code_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_unit_last (i_unit_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_byte_valid(o_byte_valid),
        .o_run_end   (o_run_end),
        .o_unit_done (o_unit_done),
        .o_status    (o_status)
    );

    // 4 ns clock
    always #2 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("nal_length_prefix_to_start_code_top: mismatch");
            $finish;
        end
    end

    // Output side backpressure
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 15);
    end

    // Accepted input beats go to the tracker before output beats are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_byte(i_data_byte, i_unit_last);
            if (o_out_valid && i_out_ready)
                sb.check_beat(o_out_byte, o_byte_valid, o_run_end, o_unit_done, o_status);
        end
    end

    // Offer one byte, with random gaps, and hold it until taken
    task automatic send_beat(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_unit_last <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sent_bytes++;
    endtask

    task automatic send_unit();
        foreach (au_bytes[i]) send_beat(au_bytes[i], i == au_bytes.size() - 1);
        au_bytes = {};
    endtask

    // Stop offering, let every owed beat arrive, then give the pipeline time to settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [2:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.width_reg = v;
    endtask

    // Big-endian length prefix at the current width
    function automatic void put_prefix(input int unsigned len);
        int lw;
        lw = sb.prefix_len();
        for (int i = lw - 1; i >= 0; i--) au_bytes.push_back(8'(len >> (8 * i)));
    endfunction

    function automatic void put_nal(input int unsigned declared, input int unsigned given,
                                    input logic bad_first);
        logic [7:0] b;
        put_prefix(declared);
        for (int i = 0; i < given; i++) begin
            b = 8'($urandom_range(255));
            if (i == 0) b[FORBIDDEN_BIT] = bad_first;
            au_bytes.push_back(b);
        end
    endfunction

    function automatic int unsigned pick_len();
        if ($urandom_range(9) == 0) return $urandom_range(40, 9);
        return $urandom_range(8, 1);
    endfunction

    // Mostly well-formed units; the rest truncated, broken or plain noise
    function automatic void build_random_unit();
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        pick = $urandom_range(99);
        au_bytes = {};
        if (pick < 70) begin
            repeat ($urandom_range(3, 1)) begin
                len = pick_len();
                put_nal(len, len, 1'b0);
            end
        end else if (pick < 80) begin
            repeat ($urandom_range(2, 1)) begin
                len = pick_len();
                put_nal(len, len, 1'b0);
            end
            cut = $urandom_range(au_bytes.size(), 1);
            while (au_bytes.size() > cut) void'(au_bytes.pop_back());
        end else if (pick < 85) begin
            put_prefix(0);
            repeat ($urandom_range(3)) au_bytes.push_back(8'($urandom_range(255)));
        end else if (pick < 90) begin
            len = $urandom_range(6, 1);
            put_nal(len, $urandom_range(len, 1), 1'b1);
        end else if (pick < 95) begin
            len = $urandom_range(8, 2);
            put_nal(len, $urandom_range(len - 1, 1), 1'b0);
        end else begin
            repeat ($urandom_range(6, 1)) au_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    initial begin
        logic [2:0] widths[8];
        int         phase_start;
        widths = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd7, 3'd4, 3'd5, 3'd6};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_unit_last = 1'b0;
        steady = 1'b0;
        sent_bytes = 0;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, 4-byte prefixes from reset: one-byte NAL, truncated field,
        // maximum length cut by the unit end, forbidden bit with sticky error
        au_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h7F};
        send_unit();
        au_bytes = '{8'h00};
        send_unit();
        au_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_unit();
        au_bytes = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h80, 8'h11};
        send_unit();

        // Width shrinks part way through a length field
        send_beat(8'h00, 1'b0);
        send_beat(8'h01, 1'b0);
        write_width(3'd2);
        au_bytes = '{8'h05, 8'h3A};
        send_unit();

        // 1-byte prefixes: zero length on the last byte, forbidden bit on the last
        // byte with and without more due, overrun inside the body
        write_width(3'd1);
        au_bytes = '{8'h00};
        send_unit();
        au_bytes = '{8'h01, 8'h80};
        send_unit();
        au_bytes = '{8'h03, 8'hFF};
        send_unit();
        au_bytes = '{8'h03, 8'h10, 8'h20};
        send_unit();

        // Random units under each width setting; two phases run without gaps
        foreach (widths[p]) begin
            write_width(widths[p]);
            steady = (p == 3 || p == 4);
            phase_start = sent_bytes;
            while (sent_bytes - phase_start < PHASE_BYTES) begin
                build_random_unit();
                send_unit();
            end
        end
        steady = 1'b0;

        wait_drained();
        if (sb.fails == 0) $display("nal_length_prefix_to_start_code_top: match");
        else $display("nal_length_prefix_to_start_code_top: mismatch");
        $finish;
    end

endmodule

FILE: nal_length_prefix_to_start_code_top.f
hw/rtl/nlpsc_pkg.sv
hw/rtl/nlpsc_front.sv
hw/rtl/nlpsc_queue.sv
hw/rtl/nlpsc_back.sv
hw/rtl/nal_length_prefix_to_start_code_top.sv
hw/rtl/nlpsc_checker.sv
test/tb_nal_length_prefix_to_start_code_top.sv
